// File: rtl/qes_pkg.sv
package qes_pkg;

   // sequence steps
   localparam logic [3:0] STEP_IDLE    = 4'd0;
   localparam logic [3:0] STEP_RD_SR2  = 4'd1;
   localparam logic [3:0] STEP_RD_SR1  = 4'd2;
   localparam logic [3:0] STEP_WE_12   = 4'd3;
   localparam logic [3:0] STEP_WR_12   = 4'd4;
   localparam logic [3:0] STEP_RD_ONLY = 4'd5;
   localparam logic [3:0] STEP_WE_1    = 4'd6;
   localparam logic [3:0] STEP_WR_1    = 4'd7;
   localparam logic [3:0] STEP_WE_ALT  = 4'd8;
   localparam logic [3:0] STEP_WR_ALT  = 4'd9;
   localparam logic [3:0] STEP_WR_SR2  = 4'd10;

   // flash opcodes
   localparam logic [7:0] OP_NONE     = 8'h00;
   localparam logic [7:0] OP_WREN     = 8'h06;
   localparam logic [7:0] OP_RDSR1    = 8'h05;
   localparam logic [7:0] OP_RDSR2    = 8'h35;
   localparam logic [7:0] OP_WRSR     = 8'h01;
   localparam logic [7:0] OP_WRSR2    = 8'h31;
   localparam logic [7:0] OP_WRSR2ALT = 8'h3E;

   // command kinds
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;

   // item function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_DONE  = 1'b1;

   // quad enable requirement codes with a sequence
   localparam logic [2:0] QER_SR2_BIT1_A = 3'd1;
   localparam logic [2:0] QER_SR1_BIT6   = 3'd2;
   localparam logic [2:0] QER_SR2_BIT7   = 3'd3;
   localparam logic [2:0] QER_SR2_BIT1_B = 3'd4;
   localparam logic [2:0] QER_SR2_BIT1_C = 3'd5;

   // bit masks and fixed payloads
   localparam logic [7:0] SR2_QE_MASK  = 8'h02;
   localparam logic [7:0] SR1_QE_MASK  = 8'h40;
   localparam logic [7:0] SR2_ALT_BYTE = 8'h80;

   typedef struct packed {
      logic [7:0] cmd_opcode;
      logic [1:0] cmd_kind;
      logic [1:0] write_len;
      logic [7:0] write_byte_first;
      logic [7:0] write_byte_second;
      logic       finished;
   } rsp_payload_type;

endpackage

// File: rtl/qes_req_if.sv
interface qes_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] read_byte;

   modport source (output valid, func, read_byte, input ready);
   modport sink (input valid, func, read_byte, output ready);
endinterface

// File: rtl/qes_rsp_if.sv
interface qes_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] cmd_opcode;
   logic [1:0] cmd_kind;
   logic [1:0] write_len;
   logic [7:0] write_byte_first;
   logic [7:0] write_byte_second;
   logic       finished;

   modport source (output valid, cmd_opcode, cmd_kind, write_len, write_byte_first,
                   write_byte_second, finished, input ready);
   modport sink (input valid, cmd_opcode, cmd_kind, write_len, write_byte_first,
                 write_byte_second, finished, output ready);
endinterface

// File: rtl/quad_enable_sequencer_unit.sv
// Quad enable sequencer for a serial flash.
//
// req channel: one item per flash event. func = 0 starts the sequence picked by
// the quad enable requirement code in csr_write_data, written via csr_write_en
// by the user only while idle (not enforced by the block); func = 1 reports the
// last flash transfer completed, read_byte carrying the status byte of a read.
// rsp channel: the next flash command (opcode, kind, payload bytes) or the
// finish mark. A done item that arrives with no sequence running yields no item.
//
// An item's command is registered into the output queue on accept and shows on
// rsp once the entries ahead of it are taken. One item is taken per cycle while
// the queue has room; the next-step decode is a few gates between the sequence
// state and the result registers. The queue holds two entries, so req stays
// ready while one result waits on a stalled receiver; req drops ready only when
// both entries are full, and resumes once rsp has taken one.
//
// Synchronous reset clears the queue, the code register (to 0) and returns the
// sequence to idle; the kept status bytes read as zero.
module quad_enable_sequencer_unit
   import qes_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   qes_req_if.sink    req,
   qes_rsp_if.source  rsp,
   input  logic       csr_write_en,
   input  logic [2:0] csr_write_data
);

   logic [2:0]      qer_mode_ff;
   logic [3:0]      step_ff, step_in;
   logic [7:0]      status_one_ff, status_one_in;
   logic [7:0]      status_two_ff, status_two_in;

   // two-entry result queue: entry zero is the head shown on rsp
   logic [1:0]      count_ff, count_in;
   rsp_payload_type slot0_ff, slot0_in;
   rsp_payload_type slot1_ff, slot1_in;

   logic            req_fire;
   logic            rsp_fire;
   logic            res_valid;
   rsp_payload_type res;

   assign req.ready = (count_ff != 2'd2);
   assign req_fire  = req.valid && req.ready;
   assign rsp_fire  = rsp.valid && rsp.ready;

   // Decode the item against the current step; state only moves on accept.
   always_comb begin
      step_in       = step_ff;
      status_one_in = status_one_ff;
      status_two_in = status_two_ff;
      res_valid     = 1'b1;
      res           = '0;

      if (req.func == FUNC_START) begin
         // a start abandons whatever sequence is running
         case (qer_mode_ff)
            QER_SR2_BIT1_A, QER_SR2_BIT1_C: begin
               res.cmd_opcode = OP_RDSR2;
               res.cmd_kind   = KIND_READ;
               step_in        = STEP_RD_SR2;
            end
            QER_SR1_BIT6: begin
               res.cmd_opcode = OP_RDSR1;
               res.cmd_kind   = KIND_READ;
               step_in        = STEP_RD_ONLY;
            end
            QER_SR2_BIT7: begin
               res.cmd_opcode = OP_WREN;
               res.cmd_kind   = KIND_WRITE;
               step_in        = STEP_WE_ALT;
            end
            QER_SR2_BIT1_B: begin
               // no write enable ahead of this one
               status_one_in        = SR2_QE_MASK;
               res.cmd_opcode       = OP_WRSR2;
               res.cmd_kind         = KIND_WRITE;
               res.write_len        = 2'd1;
               res.write_byte_first = SR2_QE_MASK;
               step_in              = STEP_WR_SR2;
            end
            default: begin
               // no sequence for this code: finish at once
               res.finished = 1'b1;
               step_in      = STEP_IDLE;
            end
         endcase
      end else begin
         case (step_ff)
            STEP_RD_SR2: begin
               status_two_in  = req.read_byte;
               res.cmd_opcode = OP_RDSR1;
               res.cmd_kind   = KIND_READ;
               step_in        = STEP_RD_SR1;
            end
            STEP_RD_SR1: begin
               status_one_in  = req.read_byte;
               res.cmd_opcode = OP_WREN;
               res.cmd_kind   = KIND_WRITE;
               step_in        = STEP_WE_12;
            end
            STEP_WE_12: begin
               status_two_in         = status_two_ff | SR2_QE_MASK;
               res.cmd_opcode        = OP_WRSR;
               res.cmd_kind          = KIND_WRITE;
               res.write_len         = 2'd2;
               res.write_byte_first  = status_one_ff;
               res.write_byte_second = status_two_ff | SR2_QE_MASK;
               step_in               = STEP_WR_12;
            end
            STEP_RD_ONLY: begin
               status_one_in  = req.read_byte;
               res.cmd_opcode = OP_WREN;
               res.cmd_kind   = KIND_WRITE;
               step_in        = STEP_WE_1;
            end
            STEP_WE_1: begin
               status_one_in        = status_one_ff | SR1_QE_MASK;
               res.cmd_opcode       = OP_WRSR;
               res.cmd_kind         = KIND_WRITE;
               res.write_len        = 2'd1;
               res.write_byte_first = status_one_ff | SR1_QE_MASK;
               step_in              = STEP_WR_1;
            end
            STEP_WE_ALT: begin
               status_one_in        = SR2_ALT_BYTE;
               res.cmd_opcode       = OP_WRSR2ALT;
               res.cmd_kind         = KIND_WRITE;
               res.write_len        = 2'd1;
               res.write_byte_first = SR2_ALT_BYTE;
               step_in              = STEP_WR_ALT;
            end
            STEP_WR_12, STEP_WR_1, STEP_WR_ALT, STEP_WR_SR2: begin
               res.finished = 1'b1;
               step_in      = STEP_IDLE;
            end
            default: begin
               // done while idle: drop the item
               res_valid = 1'b0;
               step_in   = STEP_IDLE;
            end
         endcase
      end
   end

   // Queue bookkeeping: push the new result behind whatever stays.
   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (rsp_fire) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
      if (req_fire && res_valid) begin
         if (count_in == 2'd0) begin
            slot0_in = res;
         end else begin
            slot1_in = res;
         end
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qer_mode_ff   <= 3'd0;
         step_ff       <= STEP_IDLE;
         status_one_ff <= 8'd0;
         status_two_ff <= 8'd0;
         count_ff      <= 2'd0;
      end else begin
         if (csr_write_en) begin
            qer_mode_ff <= csr_write_data;
         end
         if (req_fire) begin
            step_ff       <= step_in;
            status_one_ff <= status_one_in;
            status_two_ff <= status_two_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp.valid             = (count_ff != 2'd0);
   assign rsp.cmd_opcode        = slot0_ff.cmd_opcode;
   assign rsp.cmd_kind          = slot0_ff.cmd_kind;
   assign rsp.write_len         = slot0_ff.write_len;
   assign rsp.write_byte_first  = slot0_ff.write_byte_first;
   assign rsp.write_byte_second = slot0_ff.write_byte_second;
   assign rsp.finished          = slot0_ff.finished;

endmodule

// File: rtl/qes_checker.sv
module qes_checker
   import qes_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_cmd_opcode,
   input logic [1:0] rsp_cmd_kind,
   input logic [1:0] rsp_write_len,
   input logic       rsp_finished
);

   // hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cmd_opcode)
         && $stable(rsp_cmd_kind) && $stable(rsp_write_len) && $stable(rsp_finished))
      else $error("stalled result changed");

   // reset empties the result queue
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // input backpressure only with a result waiting
   assert property (@(posedge clock) disable iff (reset) !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   // finish mark carries no command
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_cmd_opcode == OP_NONE
         && rsp_cmd_kind == KIND_NONE && rsp_write_len == 2'd0)
      else $error("finish item carries a command");

   // a write with no payload is only a write enable
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cmd_kind == KIND_WRITE && rsp_write_len == 2'd0
         |-> rsp_cmd_opcode == OP_WREN)
      else $error("empty write that is not a write enable");

endmodule

bind quad_enable_sequencer_unit qes_checker u_qes_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_cmd_opcode (rsp.cmd_opcode),
   .rsp_cmd_kind   (rsp.cmd_kind),
   .rsp_write_len  (rsp.write_len),
   .rsp_finished   (rsp.finished)
);
